/* design/hsv_to_rgb_converter_core_assert.svh */
// assertion macros for the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

`ifndef SYNTH
// checked only out of reset
`define HSV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hsv_to_rgb assertion failed");
// checked at every edge, reset included
`define HSV_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hsv_to_rgb assertion failed");
`else
`define HSV_ASSERT(lbl, prop)
`define HSV_ASSERT_ANY(lbl, prop)
`endif

`endif

/* design/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

  // full intensity in q1.16
  localparam logic [16:0] UNIT_ONE    = 17'd65536;
  // six full turns, makes any 16-bit hue non-negative without changing it mod 5760
  localparam logic [16:0] HUE_BIAS    = 17'd34560;
  // ceil(2^27 / 960), exact floor division for 17-bit operands
  localparam logic [17:0] HUE_RECIP   = 18'd139811;
  localparam logic [9:0]  SECTOR_SPAN = 10'd960;
  localparam logic [25:0] HALF_SPAN   = 26'd480;
  localparam logic [32:0] RND_Q16     = 33'd32768;
  // ceil(2^24 / 15), exact floor division for 20-bit operands
  localparam logic [20:0] X_RECIP     = 21'd1118482;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

  // output of the front half
  typedef struct packed {
    logic        vld;
    sector_t     sector;
    logic [9:0]  frac;
    logic [32:0] vs_prod;
    logic [16:0] v;
    logic [16:0] a;
  } front_t;

  function automatic logic [16:0] clamp_unit(input logic signed [17:0] val);
    logic [16:0] res;
    if (val < 18'sd0) begin
      res = 17'd0;
    end else if (val > 18'sd65536) begin
      res = UNIT_ONE;
    end else begin
      res = val[16:0];
    end
    return res;
  endfunction

  // q mod 6 for q up to 70, via floor(q/6) = (q*43) >> 8
  function automatic sector_t sector_of(input logic [6:0] q);
    logic [12:0] prod;
    logic [3:0]  div6;
    logic [6:0]  rem;
    prod = 13'(q) * 13'd43;
    div6 = prod[11:8];
    rem  = q - 7'(div6) * 7'd6;
    return sector_t'(rem[2:0]);
  endfunction

endpackage

/* design/hsv2rgb_if.sv */
interface hsv2rgb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hue;
  logic signed [17:0] saturation;
  logic signed [17:0] brightness;
  logic signed [17:0] opacity;

  modport source (output valid, hue, saturation, brightness, opacity, input ready);
  modport sink   (input valid, hue, saturation, brightness, opacity, output ready);
endinterface

interface hsv2rgb_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] red;
  logic [16:0] green;
  logic [16:0] blue;
  logic [16:0] alpha_out;

  modport source (output valid, red, green, blue, alpha_out, input ready);
  modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

/* design/hsv_to_rgb_converter_core.sv */
// hsv plus alpha to rgba converter, six register stages
// throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined datapath
// a stalled output holds the whole pipeline in place, nothing is dropped
// reset: synchronous active-low rst_n clears all stage valid bits
`include "hsv_to_rgb_converter_core_assert.svh"

module hsv_to_rgb_converter_core (
  input  logic          clk,
  input  logic          rst_n,
  hsv2rgb_in_if.sink    in_ch,
  hsv2rgb_out_if.source out_ch
);

  // global advance: the pipeline moves unless a result is waiting and not taken
  logic                en;
  hsv2rgb_pkg::front_t front_s;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stages 1-2: hue reduction and sector split, clamping, v*s product
  hsv2rgb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_ch.valid),
    .hue        (in_ch.hue),
    .saturation (in_ch.saturation),
    .brightness (in_ch.brightness),
    .opacity    (in_ch.opacity),
    .front_o    (front_s)
  );

  // stages 3-6: chroma rounding, intermediate component, channel mixing
  hsv2rgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .front_i   (front_s),
    .out_vld   (out_ch.valid),
    .red       (out_ch.red),
    .green     (out_ch.green),
    .blue      (out_ch.blue),
    .alpha_out (out_ch.alpha_out)
  );

  // every channel stays within full intensity
  `HSV_ASSERT(a_out_range, out_ch.valid |-> (out_ch.red <= hsv2rgb_pkg::UNIT_ONE && out_ch.green <= hsv2rgb_pkg::UNIT_ONE && out_ch.blue <= hsv2rgb_pkg::UNIT_ONE && out_ch.alpha_out <= hsv2rgb_pkg::UNIT_ONE))
  // a stalled mid-pipeline transaction keeps its payload
  `HSV_ASSERT(a_front_hold, (front_s.vld && !en) |=> $stable(front_s))
  // reset empties the pipeline
  `HSV_ASSERT_ANY(a_reset_clears, !rst_n |=> !out_ch.valid)

endmodule

/* design/hsv2rgb_front.sv */
module hsv2rgb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [15:0]   hue,
  input  logic signed [17:0]   saturation,
  input  logic signed [17:0]   brightness,
  input  logic signed [17:0]   opacity,
  output hsv2rgb_pkg::front_t  front_o
);

  // stage 1: bias hue, reciprocal multiply for /960, clamp
  logic        vld1_r;
  logic [34:0] hue_prod1_r;
  logic [16:0] hue_u1_r;
  logic [16:0] s1_r, v1_r, a1_r;
  logic [16:0] hue_u_nxt;

  assign hue_u_nxt = hsv2rgb_pkg::HUE_BIAS + 17'(hue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_u1_r    <= hue_u_nxt;
      hue_prod1_r <= 35'(hue_u_nxt) * 35'(hsv2rgb_pkg::HUE_RECIP);
      s1_r        <= hsv2rgb_pkg::clamp_unit(saturation);
      v1_r        <= hsv2rgb_pkg::clamp_unit(brightness);
      a1_r        <= hsv2rgb_pkg::clamp_unit(opacity);
    end
  end

  // stage 2: sector and fraction, v*s
  logic [6:0]  span_q;
  logic [16:0] span_base;
  hsv2rgb_pkg::front_t front_r, front_nxt;

  assign span_q    = hue_prod1_r[33:27];
  assign span_base = 17'(span_q) * 17'(hsv2rgb_pkg::SECTOR_SPAN);

  always_comb begin
    front_nxt         = front_r;
    front_nxt.vld     = vld1_r;
    front_nxt.sector  = hsv2rgb_pkg::sector_of(span_q);
    front_nxt.frac    = 10'(hue_u1_r - span_base);
    front_nxt.vs_prod = 33'(34'(v1_r) * 34'(s1_r));
    front_nxt.v       = v1_r;
    front_nxt.a       = a1_r;
  end

  // valid bit is reset, the payload only follows the enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.vld <= 1'b0;
    end else if (en) begin
      front_r.vld <= front_nxt.vld;
    end
    if (en) begin
      front_r.sector  <= front_nxt.sector;
      front_r.frac    <= front_nxt.frac;
      front_r.vs_prod <= front_nxt.vs_prod;
      front_r.v       <= front_nxt.v;
      front_r.a       <= front_nxt.a;
    end
  end

  assign front_o = front_r;

endmodule

/* design/hsv2rgb_back.sv */
module hsv2rgb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  hsv2rgb_pkg::front_t front_i,
  output logic                out_vld,
  output logic [16:0]         red,
  output logic [16:0]         green,
  output logic [16:0]         blue,
  output logic [16:0]         alpha_out
);

  // stage 3: round chroma, mirror fraction in odd sectors
  logic                 vld3_r;
  logic [16:0]          c3_r, v3_r, a3_r;
  logic [9:0]           n3_r;
  hsv2rgb_pkg::sector_t sec3_r;
  logic [32:0]          c_sum;

  assign c_sum = front_i.vs_prod + hsv2rgb_pkg::RND_Q16;

  // stage 4: c*n plus half span, offset m
  logic                 vld4_r;
  logic [25:0]          t4_r;
  logic [16:0]          c4_r, m4_r, a4_r;
  hsv2rgb_pkg::sector_t sec4_r;

  // stage 5: divide by 960 as (t >> 6) / 15 via reciprocal
  logic                 vld5_r;
  logic [40:0]          xp5_r;
  logic [16:0]          c5_r, m5_r, a5_r;
  hsv2rgb_pkg::sector_t sec5_r;

  // stage 6: output register
  logic                 vld6_r;
  logic [16:0]          red_r, green_r, blue_r, alpha_r;
  logic [16:0]          x5;
  logic [16:0]          red_nxt, green_nxt, blue_nxt;

  assign x5 = xp5_r[40:24];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else if (en) begin
      vld3_r <= front_i.vld;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r   <= c_sum[32:16];
      n3_r   <= front_i.sector[0] ? (hsv2rgb_pkg::SECTOR_SPAN - front_i.frac) : front_i.frac;
      sec3_r <= front_i.sector;
      v3_r   <= front_i.v;
      a3_r   <= front_i.a;

      t4_r   <= 26'(27'(c3_r) * 27'(n3_r)) + hsv2rgb_pkg::HALF_SPAN;
      c4_r   <= c3_r;
      m4_r   <= v3_r - c3_r;
      sec4_r <= sec3_r;
      a4_r   <= a3_r;

      xp5_r  <= 41'(t4_r[25:6]) * 41'(hsv2rgb_pkg::X_RECIP);
      c5_r   <= c4_r;
      m5_r   <= m4_r;
      sec5_r <= sec4_r;
      a5_r   <= a4_r;

      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= a5_r;
    end
  end

  always_comb begin
    unique case (sec5_r)
      hsv2rgb_pkg::SEC_RED_YELLOW: begin
        red_nxt = c5_r; green_nxt = x5;    blue_nxt = 17'd0;
      end
      hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
        red_nxt = x5;    green_nxt = c5_r; blue_nxt = 17'd0;
      end
      hsv2rgb_pkg::SEC_GREEN_CYAN: begin
        red_nxt = 17'd0; green_nxt = c5_r; blue_nxt = x5;
      end
      hsv2rgb_pkg::SEC_CYAN_BLUE: begin
        red_nxt = 17'd0; green_nxt = x5;    blue_nxt = c5_r;
      end
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
        red_nxt = x5;    green_nxt = 17'd0; blue_nxt = c5_r;
      end
      default: begin
        red_nxt = c5_r; green_nxt = 17'd0; blue_nxt = x5;
      end
    endcase
    red_nxt   = red_nxt + m5_r;
    green_nxt = green_nxt + m5_r;
    blue_nxt  = blue_nxt + m5_r;
  end

  assign out_vld   = vld6_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;
  assign alpha_out = alpha_r;

endmodule

/* verif/tb_hsv_to_rgb_converter_core.sv */
module tb_hsv_to_rgb_converter_core;

  localparam int HUE_FULL_TURN   = 5760;
  localparam int HUE_SECTOR_SPAN = 960;
  localparam int Q16_ONE         = 65536;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_TAIL      = 24;

  typedef struct {
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
    logic [16:0] alpha;
  } rgba_t;

  logic clk;
  logic rst_n;
  logic idle_enable;
  int   error_count;
  int   cycle_count;
  rgba_t expected_rgba_q[$];

  hsv2rgb_in_if  in_ch();
  hsv2rgb_out_if out_ch();

  hsv_to_rgb_converter_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned saturate_q16(logic signed [17:0] val);
    if (int'(val) < 0) return 0;
    if (int'(val) > Q16_ONE) return Q16_ONE;
    return int'(val);
  endfunction

  function automatic rgba_t convert_hsva(logic signed [15:0] hue, logic signed [17:0] sat,
                                         logic signed [17:0] bri, logic signed [17:0] opa);
    int                   hue_wrapped;
    int unsigned          s, v, frac, span, chroma, inter, offset;
    hsv2rgb_pkg::sector_t sec;
    rgba_t                res;
    hue_wrapped = int'(hue) % HUE_FULL_TURN;
    if (hue_wrapped < 0) hue_wrapped += HUE_FULL_TURN;
    s = saturate_q16(sat);
    v = saturate_q16(bri);
    sec  = hsv2rgb_pkg::sector_t'(3'(hue_wrapped / HUE_SECTOR_SPAN));
    frac = hue_wrapped % HUE_SECTOR_SPAN;
    chroma = int'((longint'(v) * longint'(s) + 64'd32768) >> 16);
    // rising edge of the sector in even sectors, falling edge in odd ones
    span   = ((hue_wrapped / HUE_SECTOR_SPAN) % 2 == 1) ? (HUE_SECTOR_SPAN - frac) : frac;
    inter  = int'((longint'(chroma) * longint'(span) + HUE_SECTOR_SPAN / 2) / HUE_SECTOR_SPAN);
    offset = v - chroma;
    case (sec)
      hsv2rgb_pkg::SEC_RED_YELLOW: begin
        res.red = 17'(chroma); res.green = 17'(inter);  res.blue = 17'd0;
      end
      hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
        res.red = 17'(inter);  res.green = 17'(chroma); res.blue = 17'd0;
      end
      hsv2rgb_pkg::SEC_GREEN_CYAN: begin
        res.red = 17'd0;       res.green = 17'(chroma); res.blue = 17'(inter);
      end
      hsv2rgb_pkg::SEC_CYAN_BLUE: begin
        res.red = 17'd0;       res.green = 17'(inter);  res.blue = 17'(chroma);
      end
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
        res.red = 17'(inter);  res.green = 17'd0;       res.blue = 17'(chroma);
      end
      default: begin
        res.red = 17'(chroma); res.green = 17'd0;       res.blue = 17'(inter);
      end
    endcase
    res.red   = res.red + 17'(offset);
    res.green = res.green + 17'(offset);
    res.blue  = res.blue + 17'(offset);
    res.alpha = 17'(saturate_q16(opa));
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 2);
    if (pick < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] random_hue();
    if ($urandom_range(0, 9) < 6) return 16'($urandom);
    // land on or next to a sector edge, either turn direction
    return 16'((HUE_SECTOR_SPAN * $urandom_range(0, 6) + $urandom_range(0, 2) - 1)
               * ($urandom_range(0, 1) ? 1 : -1));
  endfunction

  function automatic logic signed [17:0] random_q16();
    case ($urandom_range(0, 9))
      0, 1: return 18'($urandom);
      2: begin
        case ($urandom_range(0, 5))
          0: return 18'sd0;
          1: return 18'sd1;
          2: return 18'sd65535;
          3: return 18'sd65536;
          4: return 18'sd65537;
          default: return -18'sd1;
        endcase
      end
      default: return 18'($urandom_range(0, Q16_ONE));
    endcase
  endfunction

  task automatic send_pixel(logic signed [15:0] hue, logic signed [17:0] sat,
                            logic signed [17:0] bri, logic signed [17:0] opa);
    int gap;
    gap = (idle_enable && $urandom_range(0, 2) == 0) ? idle_cycles() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.hue        <= hue;
    in_ch.saturation <= sat;
    in_ch.brightness <= bri;
    in_ch.opacity    <= opa;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_rgba_q.push_back(convert_hsva(hue, sat, bri, opa));
  endtask

  task automatic send_random_pixels(int count);
    repeat (count) send_pixel(random_hue(), random_q16(), random_q16(), random_q16());
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_rgba_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    // one pure hue in the middle of each sector, plus both sector ends
    send_pixel(16'sd0,    18'sd65536, 18'sd65536, 18'sd65536);
    send_pixel(16'sd480,  18'sd65536, 18'sd65536, 18'sd65536);
    send_pixel(16'sd1440, 18'sd65536, 18'sd65536, 18'sd65536);
    send_pixel(16'sd2400, 18'sd65536, 18'sd65536, 18'sd65536);
    send_pixel(16'sd3360, 18'sd65536, 18'sd65536, 18'sd65536);
    send_pixel(16'sd4320, 18'sd65536, 18'sd65536, 18'sd65536);
    send_pixel(16'sd5280, 18'sd65536, 18'sd65536, 18'sd65536);
    send_pixel(16'sd5759, 18'sd65536, 18'sd65536, 18'sd65536);
    send_pixel(16'sd959,  18'sd65536, 18'sd65536, 18'sd0);
    send_pixel(16'sd960,  18'sd65536, 18'sd65536, 18'sd0);
    // hue past one turn and negative hue wrap
    send_pixel(16'sd5760,  18'sd65536, 18'sd65536, 18'sd65536);
    send_pixel(-16'sd1,    18'sd65536, 18'sd40000, 18'sd65536);
    send_pixel(-16'sd5760, 18'sd20000, 18'sd70000, -18'sd1);
    send_pixel(-16'sd2881, 18'sd65536, 18'sd65536, 18'sd65536);
    send_pixel(-16'sd32768, 18'sd50000, 18'sd60000, 18'sd30000);
    send_pixel(16'sd32767,  18'sd50000, 18'sd60000, 18'sd30000);
    // grey from zero saturation and from a chroma that rounds away
    send_pixel(16'sd2000, 18'sd0, 18'sd45000, 18'sd65536);
    send_pixel(16'sd3000, 18'sd1, 18'sd1, 18'sd65536);
    // rounding exactly on the half for chroma and for the ramp term
    send_pixel(16'sd100, 18'sd32768, 18'sd1, 18'sd100);
    send_pixel(16'sd480, 18'sd65536, 18'sd1, 18'sd200);
    // clamping of all three q2.16 fields at both ends
    send_pixel(16'sd1500, -18'sd131072, -18'sd131072, -18'sd131072);
    send_pixel(16'sd1500, 18'sd131071, 18'sd131071, 18'sd131071);
    send_pixel(16'sd4000, 18'sd65537, 18'sd65535, 18'sd65537);
    send_pixel(16'sd4801, 18'sd40000, 18'sd50000, 18'sd65535);
  endtask

  task automatic test_random_pixels();
    send_random_pixels(1000);
  endtask

  task automatic test_back_to_back();
    idle_enable <= 1'b0;
    send_random_pixels(300);
    idle_enable <= 1'b1;
  endtask

  task automatic test_pause_for_drain();
    wait_results_drained();
    send_random_pixels(200);
  endtask

  // sink side ready with random stalls
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_enable && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
      end
    end
  end

  task automatic check_channel(string label, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t %s expected %0d actual %0d", $time, label, want, got);
    end
  endtask

  // compare each result transaction with the oldest prediction
  initial begin
    rgba_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_rgba_q.size() == 0) begin
          error_count++;
          $display("%0t unexpected result expected none actual %0d %0d %0d %0d", $time,
                   out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha_out);
        end else begin
          want = expected_rgba_q.pop_front();
          check_channel("red", want.red, out_ch.red);
          check_channel("green", want.green, out_ch.green);
          check_channel("blue", want.blue, out_ch.blue);
          check_channel("alpha_out", want.alpha, out_ch.alpha_out);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[hsv_to_rgb_converter_core] ERROR");
    $finish;
  end

  initial begin
    error_count      = 0;
    rst_n            <= 1'b0;
    idle_enable      <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.hue        <= '0;
    in_ch.saturation <= '0;
    in_ch.brightness <= '0;
    in_ch.opacity    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_random_pixels();
    test_back_to_back();
    test_pause_for_drain();
    wait_results_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0 && expected_rgba_q.size() == 0) begin
      $display("[hsv_to_rgb_converter_core] OK");
    end else begin
      $display("[hsv_to_rgb_converter_core] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/hsv2rgb_pkg.sv
design/hsv2rgb_if.sv
design/hsv2rgb_front.sv
design/hsv2rgb_back.sv
design/hsv_to_rgb_converter_core.sv
verif/tb_hsv_to_rgb_converter_core.sv
